// ===== hw/rtl/rhc_pkg.sv =====
package rhc_pkg;

	// Quotient bits produced by each divider chain, one bit per stage
	localparam int DIV_STEPS = 16;

	localparam int CH_W      = 8;   // one color channel
	localparam int SUM_W     = 9;   // max + min
	localparam int HDEN_W    = 11;  // 6 * d, up to 1530
	localparam int QUO_W     = 16;  // hue and saturation quotients
	localparam int LY_W      = 15;  // 64 * (max + min)
	localparam int LIGHT_W   = 16;

	localparam logic [SUM_W-1:0]   SUM_HALF     = 9'd255;
	localparam logic [SUM_W-1:0]   SUM_FULL     = 9'd510;
	localparam logic [LIGHT_W-1:0] RECIP_DIV    = 16'd255;
	localparam logic [QUO_W:0]     Q15_ONE      = 17'd32768;

	// Which channel holds the maximum
	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

endpackage

// ===== hw/rtl/rgb_to_hsl_convert_core.sv =====
// Channel   Direction  Handshake              Fields
// pix       in         pix_valid / pix_ready  red_in, green_in, blue_in
// hsl       out        hsl_valid / hsl_ready  hue_out, sat_out, light_out
//
// One pixel per clock sustained while hsl_ready stays high. Stages: max/min stage,
// operand stage, then 16 restoring-divider stages (one quotient bit each) for hue
// and saturation side by side; the last divider stage is the output register.
// arst_n clears all stage valid bits; data registers are not reset.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse under a stall and the input takes beats until every stage holds one.
module rgb_to_hsl_convert_core
	import rhc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  logic [CH_W-1:0]    red_in,
	input  logic [CH_W-1:0]    green_in,
	input  logic [CH_W-1:0]    blue_in,
	output logic               hsl_valid,
	input  logic               hsl_ready,
	output logic [QUO_W-1:0]   hue_out,
	output logic [QUO_W-1:0]   sat_out,
	output logic [LIGHT_W-1:0] light_out
);

	// ---------------- stage 1: max, min, difference, sum
	logic              vld_s1;
	logic [CH_W-1:0]   r_s1, g_s1, b_s1, d_s1;
	logic [SUM_W-1:0]  s_s1;
	max_sel_t          sel_s1;

	logic              g_gt_r;
	logic [CH_W-1:0]   mx_c, mn_c, rg_mx, rg_mn;
	max_sel_t          sel_c;

	always_comb begin
		g_gt_r = green_in > red_in;
		rg_mx  = g_gt_r ? green_in : red_in;
		rg_mn  = (green_in < red_in) ? green_in : red_in;
		if (blue_in > rg_mx) begin
			sel_c = SEL_BLUE;
			mx_c  = blue_in;
		end else if (g_gt_r) begin
			sel_c = SEL_GREEN;
			mx_c  = rg_mx;
		end else begin
			sel_c = SEL_RED;
			mx_c  = rg_mx;
		end
		mn_c = (blue_in < rg_mn) ? blue_in : rg_mn;
	end

	// ---------------- stage 2: divider operands and lightness estimate
	logic              vld_s2;
	logic [HDEN_W-1:0] hnum_s2, hden_s2;
	logic [CH_W-1:0]   sd_s2, sden_s2;
	logic              grey_s2;
	logic [LY_W-1:0]   ly_s2;
	logic [CH_W-1:0]   lq_s2;

	logic [HDEN_W-1:0] d_w, hnum_c, hden_c;
	logic [HDEN_W-1:0] r_w, g_w, b_w;
	logic [CH_W-1:0]   sden_c;
	logic [LY_W-1:0]   ly_c;
	logic [LY_W+8:0]   lprod_c;

	always_comb begin
		d_w    = HDEN_W'(d_s1);
		r_w    = HDEN_W'(r_s1);
		g_w    = HDEN_W'(g_s1);
		b_w    = HDEN_W'(b_s1);
		hden_c = (d_w << 2) + (d_w << 1);
		case (sel_s1)
			SEL_RED:   hnum_c = (g_s1 >= b_s1) ? (g_w - b_w) : (hden_c - (b_w - g_w));
			SEL_GREEN: hnum_c = (d_w << 1) + b_w - r_w;
			SEL_BLUE:  hnum_c = (d_w << 2) + r_w - g_w;
			default:   hnum_c = '0;
		endcase
		// above mid-grey the saturation divisor folds to 510 - s
		sden_c  = (s_s1 > SUM_HALF) ? CH_W'(SUM_FULL - s_s1) : s_s1[CH_W-1:0];
		// lightness = 64s + floor(64s / 255); estimate the quotient via *257 >> 16
		ly_c    = {s_s1, 6'b0};
		lprod_c = (LY_W+9)'({ly_c, 8'b0}) + (LY_W+9)'(ly_c);
	end

	// ---------------- divider stages
	logic              vld_sd  [DIV_STEPS];
	logic [HDEN_W-1:0] hrem_sd [DIV_STEPS];
	logic [HDEN_W-1:0] hden_sd [DIV_STEPS];
	logic [QUO_W-1:0]  hq_sd   [DIV_STEPS];
	logic [CH_W-1:0]   srem_sd [DIV_STEPS];
	logic [CH_W-1:0]   sden_sd [DIV_STEPS];
	logic [QUO_W-1:0]  sq_sd   [DIV_STEPS];
	logic              grey_sd [DIV_STEPS];
	logic [LIGHT_W-1:0] lt_sd  [DIV_STEPS];

	logic [HDEN_W-1:0] hrem_i [DIV_STEPS];
	logic [HDEN_W-1:0] hden_i [DIV_STEPS];
	logic [QUO_W-1:0]  hq_i   [DIV_STEPS];
	logic [CH_W-1:0]   srem_i [DIV_STEPS];
	logic [CH_W-1:0]   sden_i [DIV_STEPS];
	logic [QUO_W-1:0]  sq_i   [DIV_STEPS];
	logic              grey_i [DIV_STEPS];
	logic [LIGHT_W-1:0] lt_i  [DIV_STEPS];
	logic              vld_i  [DIV_STEPS];

	logic [HDEN_W-1:0] hrem_n [DIV_STEPS];
	logic [QUO_W-1:0]  hq_n   [DIV_STEPS];
	logic [CH_W-1:0]   srem_n [DIV_STEPS];
	logic [QUO_W-1:0]  sq_n   [DIV_STEPS];
	logic [LIGHT_W-1:0] lt_n  [DIV_STEPS];

	logic [LIGHT_W-1:0] lrem_c, lbase_c;

	// stage inputs: the first divider stage takes from stage 2
	always_comb begin
		hrem_i[0] = hnum_s2;
		hden_i[0] = hden_s2;
		hq_i[0]   = '0;
		srem_i[0] = sd_s2;
		sden_i[0] = sden_s2;
		sq_i[0]   = '0;
		grey_i[0] = grey_s2;
		lt_i[0]   = '0;
		vld_i[0]  = vld_s2;
		for (int k = 1; k < DIV_STEPS; k++) begin
			hrem_i[k] = hrem_sd[k-1];
			hden_i[k] = hden_sd[k-1];
			hq_i[k]   = hq_sd[k-1];
			srem_i[k] = srem_sd[k-1];
			sden_i[k] = sden_sd[k-1];
			sq_i[k]   = sq_sd[k-1];
			grey_i[k] = grey_sd[k-1];
			lt_i[k]   = lt_sd[k-1];
			vld_i[k]  = vld_sd[k-1];
		end
	end

	// one restoring step per stage on each chain
	always_comb begin
		logic [HDEN_W:0] htr;
		logic [CH_W:0]   str;
		logic            hge, sge;
		lbase_c = LIGHT_W'(ly_s2) + LIGHT_W'(lq_s2);
		lrem_c  = LIGHT_W'(ly_s2) - (({8'b0, lq_s2} << 8) - LIGHT_W'(lq_s2));
		for (int k = 0; k < DIV_STEPS; k++) begin
			htr = {hrem_i[k], 1'b0};
			hge = htr >= {1'b0, hden_i[k]};
			hrem_n[k] = hge ? HDEN_W'(htr - {1'b0, hden_i[k]}) : htr[HDEN_W-1:0];
			hq_n[k]   = {hq_i[k][QUO_W-2:0], hge};
			// first saturation step compares d itself (d <= divisor, top bit is 2^15)
			str = (k == 0) ? {1'b0, srem_i[k]} : {srem_i[k], 1'b0};
			sge = str >= {1'b0, sden_i[k]};
			srem_n[k] = sge ? CH_W'(str - {1'b0, sden_i[k]}) : str[CH_W-1:0];
			sq_n[k]   = {sq_i[k][QUO_W-2:0], sge};
			if (k == 0) begin
				lt_n[k] = (lrem_c >= RECIP_DIV) ? lbase_c + LIGHT_W'(1) : lbase_c;
			end else begin
				lt_n[k] = lt_i[k];
			end
			// grey pixel: drop both quotients at the output register
			if (k == DIV_STEPS - 1 && grey_i[k]) begin
				hq_n[k] = '0;
				sq_n[k] = '0;
			end
		end
	end

	// ---------------- stage enables, back to front
	logic en_s1, en_s2;
	logic en_sd [DIV_STEPS];

	always_comb begin
		en_sd[DIV_STEPS-1] = !vld_sd[DIV_STEPS-1] || hsl_ready;
		for (int k = DIV_STEPS - 2; k >= 0; k--) begin
			en_sd[k] = !vld_sd[k] || en_sd[k+1];
		end
		en_s2 = !vld_s2 || en_sd[0];
		en_s1 = !vld_s1 || en_s2;
	end

	assign pix_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else begin
			if (en_s1) vld_s1 <= pix_valid;
			if (en_s2) vld_s2 <= vld_s1;
			for (int k = 0; k < DIV_STEPS; k++) begin
				if (en_sd[k]) vld_sd[k] <= vld_i[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			r_s1   <= red_in;
			g_s1   <= green_in;
			b_s1   <= blue_in;
			d_s1   <= mx_c - mn_c;
			s_s1   <= SUM_W'(mx_c) + SUM_W'(mn_c);
			sel_s1 <= sel_c;
		end
		if (en_s2) begin
			hnum_s2 <= hnum_c;
			hden_s2 <= hden_c;
			sd_s2   <= d_s1;
			sden_s2 <= sden_c;
			grey_s2 <= (d_s1 == '0);
			ly_s2   <= ly_c;
			lq_s2   <= lprod_c[LY_W+8:16];
		end
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (en_sd[k]) begin
				hrem_sd[k] <= hrem_n[k];
				hden_sd[k] <= hden_i[k];
				hq_sd[k]   <= hq_n[k];
				srem_sd[k] <= srem_n[k];
				sden_sd[k] <= sden_i[k];
				sq_sd[k]   <= sq_n[k];
				grey_sd[k] <= grey_i[k];
				lt_sd[k]   <= lt_n[k];
			end
		end
	end

	assign hsl_valid = vld_sd[DIV_STEPS-1];
	assign hue_out   = hq_sd[DIV_STEPS-1];
	assign sat_out   = sq_sd[DIV_STEPS-1];
	assign light_out = lt_sd[DIV_STEPS-1];

	// ---------------- assertions
	logic all_full;

	always_comb begin
		all_full = vld_s1 && vld_s2;
		for (int k = 0; k < DIV_STEPS; k++) begin
			all_full = all_full && vld_sd[k];
		end
	end

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> all_full)
		else $error("input stalled while a stage is empty");

	a_hue_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(hsl_valid && !grey_sd[DIV_STEPS-1]) |->
			(hrem_sd[DIV_STEPS-1] < hden_sd[DIV_STEPS-1]))
		else $error("hue remainder not below divisor");

	a_sat_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(hsl_valid && !grey_sd[DIV_STEPS-1]) |->
			(srem_sd[DIV_STEPS-1] < sden_sd[DIV_STEPS-1]))
		else $error("saturation remainder not below divisor");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> ({1'b0, sat_out} <= Q15_ONE))
		else $error("saturation above full scale");

	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> ({1'b0, light_out} <= Q15_ONE))
		else $error("lightness above full scale");

endmodule

// ===== bench/rgb_to_hsl_convert_core_tb.sv =====
`timescale 1ns / 100ps

module rgb_to_hsl_convert_core_tb
	import rhc_pkg::*;
();

	localparam int Q15_SCALE   = 32768;
	localparam int Q16_TURN    = 65536;
	localparam int SUM_SPAN    = 510;
	localparam int IDLE_PCT    = 9;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [QUO_W-1:0]   hue;
		logic [QUO_W-1:0]   sat;
		logic [LIGHT_W-1:0] light;
	} hsl_pix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               pix_valid = 1'b0;
	logic               pix_ready;
	logic [CH_W-1:0]    red_in = '0;
	logic [CH_W-1:0]    green_in = '0;
	logic [CH_W-1:0]    blue_in = '0;
	logic               hsl_valid;
	logic               hsl_ready = 1'b0;
	logic [QUO_W-1:0]   hue_out;
	logic [QUO_W-1:0]   sat_out;
	logic [LIGHT_W-1:0] light_out;

	hsl_pix_t hsl_expected[$];
	bit       steady = 1'b0;
	int       errors = 0;
	int       pixels_taken = 0;
	int       pixels_checked = 0;
	int       grey_count = 0;
	int       tie_count = 0;

	rgb_to_hsl_convert_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.hsl_valid (hsl_valid),
		.hsl_ready (hsl_ready),
		.hue_out   (hue_out),
		.sat_out   (sat_out),
		.light_out (light_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic hsl_pix_t hsl_of_rgb(input logic [CH_W-1:0] r, g, b);
		max_sel_t winner;
		int       top;
		int       bot;
		int       span;
		int       total;
		int       turn_num;
		int       quo;
		hsl_pix_t res;
		top = r;
		bot = r;
		winner = SEL_RED;
		// red keeps ties; green and blue must be strictly above
		if (g > top) begin
			top = g;
			winner = SEL_GREEN;
		end
		if (b > top) begin
			top = b;
			winner = SEL_BLUE;
		end
		if (g < bot)
			bot = g;
		if (b < bot)
			bot = b;
		span = top - bot;
		total = top + bot;
		quo = (total * Q15_SCALE) / SUM_SPAN;
		res.light = quo[LIGHT_W-1:0];
		res.hue = '0;
		res.sat = '0;
		if (span != 0) begin
			if (total > 255)
				quo = (span * Q15_SCALE) / (SUM_SPAN - total);
			else
				quo = (span * Q15_SCALE) / total;
			res.sat = quo[QUO_W-1:0];
			case (winner)
				SEL_RED:   turn_num = int'(g) - int'(b) + ((g < b) ? 6 * span : 0);
				SEL_GREEN: turn_num = int'(b) - int'(r) + 2 * span;
				default:   turn_num = int'(r) - int'(g) + 4 * span;
			endcase
			quo = (turn_num * Q16_TURN) / (6 * span);
			res.hue = quo[QUO_W-1:0];
		end
		return res;
	endfunction

	// receiver side: stall at random unless the steady phase is on
	always @(negedge clk)
		hsl_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		hsl_pix_t want;
		if (arst_n) begin
			if (hsl_valid && hsl_ready) begin
				if (hsl_expected.size() == 0) begin
					$display("%0t: result beat with nothing expected: hue %0d sat %0d light %0d",
						$time, hue_out, sat_out, light_out);
					errors++;
				end else begin
					want = hsl_expected.pop_front();
					pixels_checked++;
					if (hue_out !== want.hue) begin
						$display("%0t: hue expected %0d actual %0d", $time, want.hue, hue_out);
						errors++;
					end
					if (sat_out !== want.sat) begin
						$display("%0t: sat expected %0d actual %0d", $time, want.sat, sat_out);
						errors++;
					end
					if (light_out !== want.light) begin
						$display("%0t: light expected %0d actual %0d",
							$time, want.light, light_out);
						errors++;
					end
				end
			end
			if (pix_valid && pix_ready) begin
				hsl_expected.push_back(hsl_of_rgb(red_in, green_in, blue_in));
				pixels_taken++;
				if (red_in == green_in && green_in == blue_in)
					grey_count++;
				else if (red_in == green_in || green_in == blue_in || red_in == blue_in)
					tie_count++;
			end
		end
	end

	// called just after a falling edge; returns just after the falling edge past the beat
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do
			@(posedge clk);
		while (!pix_ready);
		@(negedge clk);
	endtask

	task automatic send_random_pixel();
		logic [CH_W-1:0] r, g, b;
		int              pick;
		r = CH_W'($urandom_range(255));
		g = CH_W'($urandom_range(255));
		b = CH_W'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 8) begin
			g = r;
			b = r;
		end else if (pick < 14) begin
			g = r;
		end else if (pick < 20) begin
			b = g;
		end else if (pick < 26) begin
			b = r;
		end
		send_pixel(r, g, b);
	endtask

	task automatic test_corner_pixels();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd128, 8'd128, 8'd127);
		send_pixel(8'd129, 8'd127, 8'd127);
		send_pixel(8'd200, 8'd10, 8'd100);
		send_pixel(8'd200, 8'd100, 8'd10);
		send_pixel(8'd30, 8'd200, 8'd60);
		send_pixel(8'd30, 8'd60, 8'd200);
		send_pixel(8'd1, 8'd2, 8'd3);
		send_pixel(8'd254, 8'd255, 8'd253);
		send_pixel(8'd170, 8'd85, 8'd255);
	endtask

	task automatic test_random_pixels();
		repeat (650)
			send_random_pixel();
	endtask

	// no idling on either side: sustained one beat per clock
	task automatic test_back_to_back();
		steady = 1'b1;
		repeat (330)
			send_random_pixel();
		steady = 1'b0;
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: cycle limit reached, %0d results outstanding",
			$time, hsl_expected.size());
		$display("rgb_to_hsl_convert_core_tb: done, errors");
		$finish;
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corner_pixels();
		test_random_pixels();
		test_back_to_back();
		pix_valid <= 1'b0;
		while (hsl_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d pixels with %0d results checked, %0d grey and %0d with a tie",
			pixels_taken, pixels_checked, grey_count, tie_count);
		$display("random stalls on both sides, then a back-to-back stretch; %0d mismatches",
			errors);
		if (errors == 0)
			$display("rgb_to_hsl_convert_core_tb: done, clean");
		else
			$display("rgb_to_hsl_convert_core_tb: done, errors");
		$finish;
	end

endmodule
